>>> design/psrs_pkg.sv
// Shared types, constants and codes for the position/static report scheduler.
// No dependencies; imported by every module of the block.
package psrs_pkg;

    // Time arithmetic width (all time math wraps at 2^TIME_BITS)
    localparam int TIME_BITS = 32;

    // Field widths
    localparam int INTERVAL_BITS = 16;
    localparam int SPEED_IN_BITS = 14;
    localparam int SPEED_FRAC    = 8;
    localparam int SPEED_BITS    = SPEED_IN_BITS + SPEED_FRAC;
    localparam int SUM_BITS      = SPEED_BITS + 3;
    localparam int CLOCK_BITS    = 32;
    localparam int TYPE_BITS     = 6;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_COUNT     = 5;
    localparam int CFG_IDX_BITS  = $clog2(CFG_COUNT);
    localparam int MAX_RESULTS   = 3;
    localparam int COUNT_BITS    = 2;

    // Divide by five: floor(x / 5) = (x * RECIP5) >> RECIP_SHIFT for x < 2^26
    localparam int RECIP_SHIFT = 27;
    localparam logic [SUM_BITS-1:0] RECIP5 = SUM_BITS'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_INTERVAL   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FAST_INTERVAL   = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_STATIC_INTERVAL = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_THRESHOLD = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_STATION_VALID   = CFG_IDX_BITS'(4);

    // Command codes
    localparam logic [1:0] CMD_FIX       = 2'd0;
    localparam logic [1:0] CMD_CLOCK     = 2'd1;
    localparam logic [1:0] CMD_INTERROG  = 2'd2;

    // Report kinds
    localparam logic [1:0] KIND_POSITION = 2'd0;
    localparam logic [1:0] KIND_STATIC_A = 2'd1;
    localparam logic [1:0] KIND_STATIC_B = 2'd2;

    // Interrogated message numbers
    localparam logic [TYPE_BITS-1:0] MSG_POSITION = TYPE_BITS'(18);
    localparam logic [TYPE_BITS-1:0] MSG_STATIC   = TYPE_BITS'(24);

    typedef struct packed {
        logic [1:0]               command;
        logic [CLOCK_BITS-1:0]    clock_time;
        logic [SPEED_IN_BITS-1:0] fix_speed;
        logic                     channels_ready;
        logic                     radio_ready;
        logic                     send_permitted;
        logic [TYPE_BITS-1:0]     requested_type;
        logic                     requested_channel;
    } in_item_t;

    typedef struct packed {
        logic [1:0] report_kind;
        logic       tx_channel;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] slow_interval;
        logic [INTERVAL_BITS-1:0] fast_interval;
        logic [INTERVAL_BITS-1:0] static_interval;
        logic [SPEED_IN_BITS-1:0] speed_threshold;
        logic                     station_valid;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       chan;
    } report_t;

    // Reports from one event, entry 0 goes out first
    typedef struct packed {
        logic [COUNT_BITS-1:0]         count;
        report_t [MAX_RESULTS-1:0]     entry;
    } bundle_t;

endpackage

>>> design/psrs_cfg.sv
// Configuration register file for the report scheduler.
// Depends on psrs_pkg.
module psrs_cfg
    import psrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SLOW_INTERVAL:   cfg_next.slow_interval   = cfg_wdata;
                REG_FAST_INTERVAL:   cfg_next.fast_interval   = cfg_wdata;
                REG_STATIC_INTERVAL: cfg_next.static_interval = cfg_wdata;
                REG_SPEED_THRESHOLD: cfg_next.speed_threshold = cfg_wdata[SPEED_IN_BITS-1:0];
                REG_STATION_VALID:   cfg_next.station_valid   = cfg_wdata[0];
                default:             cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_interval   <= INTERVAL_BITS'(180);
            cfg_reg.fast_interval   <= INTERVAL_BITS'(30);
            cfg_reg.static_interval <= INTERVAL_BITS'(360);
            cfg_reg.speed_threshold <= SPEED_IN_BITS'(32);
            cfg_reg.station_valid   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/psrs_sched.sv
// Input register and scheduling logic: time keeping, speed smoothing, due checks.
// Depends on psrs_pkg.
module psrs_sched
    import psrs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     bundle_free,
    output logic     bundle_load,
    output bundle_t  bundle
);

    logic                  in_valid_reg;
    in_item_t              item_reg;
    logic [TIME_BITS-1:0]  now_reg,      now_next;
    logic [TIME_BITS-1:0]  last_pos_reg, last_pos_next;
    logic [TIME_BITS-1:0]  last_stat_reg, last_stat_next;
    logic [SPEED_BITS-1:0] speed_reg,    speed_next;
    logic                  pos_ch_reg,   pos_ch_next;
    logic                  stat_ch_reg,  stat_ch_next;

    logic                     fire;
    logic                     emit;
    logic                     fix_ok;
    logic [SUM_BITS-1:0]      speed_sum;
    logic [2*SUM_BITS-1:0]    speed_prod;
    logic [SPEED_BITS-1:0]    speed_new;
    logic [INTERVAL_BITS-1:0] pos_interval;
    logic [TIME_BITS-1:0]     clock_t;
    logic                     pos_due;
    logic                     stat_due;
    logic                     has_pos;
    logic                     has_stat;
    logic                     pos_chan;
    logic                     stat_chan;

    assign emit    = cfg.station_valid;
    assign clock_t = TIME_BITS'(item_reg.clock_time);
    assign fix_ok  = item_reg.channels_ready && item_reg.radio_ready
                     && item_reg.send_permitted && (now_reg != '0);

    // 0.8 * old + 0.2 * new, rounded: (4*old + new + 2) / 5
    assign speed_sum  = {1'b0, speed_reg, 2'b00}
                      + SUM_BITS'({item_reg.fix_speed, {SPEED_FRAC{1'b0}}})
                      + SUM_BITS'(2);
    assign speed_prod = speed_sum * RECIP5;
    assign speed_new  = speed_prod[RECIP_SHIFT +: SPEED_BITS];

    assign pos_interval = (speed_new < {cfg.speed_threshold, {SPEED_FRAC{1'b0}}})
                          ? cfg.slow_interval : cfg.fast_interval;
    assign pos_due  = (now_reg - last_pos_reg) > TIME_BITS'(pos_interval);
    assign stat_due = (now_reg - last_stat_reg) > TIME_BITS'(cfg.static_interval);

    always_comb
    begin
        now_next       = now_reg;
        last_pos_next  = last_pos_reg;
        last_stat_next = last_stat_reg;
        speed_next     = speed_reg;
        pos_ch_next    = pos_ch_reg;
        stat_ch_next   = stat_ch_reg;
        has_pos        = 1'b0;
        has_stat       = 1'b0;
        pos_chan       = pos_ch_reg;
        stat_chan      = stat_ch_reg;
        case (item_reg.command)
            CMD_FIX:
            begin
                if (fix_ok)
                begin
                    speed_next = speed_new;
                    if (pos_due)
                    begin
                        has_pos       = emit;
                        pos_ch_next   = ~pos_ch_reg;
                        last_pos_next = now_reg;
                    end
                    if (stat_due)
                    begin
                        has_stat       = emit;
                        stat_ch_next   = ~stat_ch_reg;
                        last_stat_next = now_reg;
                    end
                end
            end
            CMD_CLOCK:
            begin
                if (now_reg == '0)
                begin
                    last_pos_next  = clock_t - TIME_BITS'(cfg.slow_interval >> 1);
                    last_stat_next = clock_t - TIME_BITS'(cfg.static_interval >> 1);
                end
                now_next = clock_t;
            end
            CMD_INTERROG:
            begin
                has_pos   = emit && (item_reg.requested_type == MSG_POSITION);
                has_stat  = emit && (item_reg.requested_type == MSG_STATIC);
                pos_chan  = item_reg.requested_channel;
                stat_chan = item_reg.requested_channel;
            end
            default:
            begin
                has_pos = 1'b0;
            end
        endcase
    end

    // Pack reports in order: position first, then static A and B
    always_comb
    begin
        bundle.count = {has_stat, 1'b0} + {1'b0, has_pos};
        bundle.entry[0] = has_pos ? '{kind: KIND_POSITION, chan: pos_chan}
                                  : '{kind: KIND_STATIC_A, chan: stat_chan};
        bundle.entry[1] = has_pos ? '{kind: KIND_STATIC_A, chan: stat_chan}
                                  : '{kind: KIND_STATIC_B, chan: stat_chan};
        bundle.entry[2] = '{kind: KIND_STATIC_B, chan: stat_chan};
    end

    // An event with no reports retires without the output stage
    assign fire        = in_valid_reg && ((bundle.count == '0) || bundle_free);
    assign bundle_load = fire && (bundle.count != '0);
    assign in_ready    = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            now_reg       <= '0;
            last_pos_reg  <= '0;
            last_stat_reg <= '0;
            speed_reg     <= '0;
            pos_ch_reg    <= 1'b0;
            stat_ch_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                now_reg       <= now_next;
                last_pos_reg  <= last_pos_next;
                last_stat_reg <= last_stat_next;
                speed_reg     <= speed_next;
                pos_ch_reg    <= pos_ch_next;
                stat_ch_reg   <= stat_ch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

endmodule

>>> design/psrs_outq.sv
// Result register: holds an event's reports and sends one per ready cycle.
// Depends on psrs_pkg.
module psrs_outq
    import psrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      bundle_load,
    input  bundle_t   bundle,
    output logic      bundle_free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [COUNT_BITS-1:0]     count_reg;
    report_t [MAX_RESULTS-1:0] entry_reg;
    logic                      out_fire;

    assign out_valid   = (count_reg != '0);
    assign out_fire    = out_valid && out_ready;
    assign bundle_free = (count_reg == '0) || ((count_reg == COUNT_BITS'(1)) && out_ready);

    assign out_data.report_kind = entry_reg[0].kind;
    assign out_data.tx_channel  = entry_reg[0].chan;
    assign out_data.last_of_run = (count_reg == COUNT_BITS'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (bundle_load)
        begin
            count_reg <= bundle.count;
        end
        else if (out_fire)
        begin
            count_reg <= count_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle_load)
        begin
            entry_reg <= bundle.entry;
        end
        else if (out_fire)
        begin
            // advance the run by one report
            entry_reg[0] <= entry_reg[1];
            entry_reg[1] <= entry_reg[2];
        end
    end

endmodule

>>> design/position_static_report_scheduler.sv
// Top level of the position/static report scheduler.
// Depends on psrs_pkg, psrs_cfg, psrs_sched and psrs_outq.
//
//   port group   direction  handshake               payload
//   ----------   ---------  ---------------------   ---------------------------
//   in_*         input      in_valid / in_ready     in_data  (in_item_t)
//   out_*        output     out_valid / out_ready   out_data (out_item_t)
//   cfg_*        input      cfg_wr_en only          cfg_index, cfg_wdata
//
// An event is registered at transfer and evaluated in the next cycle; its reports
// (zero to three) land in the result register and leave one per cycle while
// out_ready is high, so the block sustains one event per cycle when it emits
// nothing; an event with reports waits until the result register, drained by
// the single-report output port, is free.
// Reset (rst_n, async, active low) restores register defaults and clears time,
// speed and channel state; no clearing pass is needed.
// A stalled output holds its report; the input register still takes new events
// while the result register drains, until it holds an event with reports.
module position_static_report_scheduler
    import psrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_data
);

    cfg_t    cfg;
    bundle_t bundle;
    logic    bundle_load;
    logic    bundle_free;

    // Configuration registers
    psrs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register, scheduler state and due logic
    psrs_sched u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .bundle_free (bundle_free),
        .bundle_load (bundle_load),
        .bundle      (bundle)
    );

    // Result register, drain one report per transfer
    psrs_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .bundle_load (bundle_load),
        .bundle      (bundle),
        .bundle_free (bundle_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

>>> design/psrs_checker.sv
// Port-level checks for the report scheduler, bound to the top level.
// Depends on psrs_pkg and position_static_report_scheduler.
module psrs_checker
    import psrs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input out_item_t                out_data
);

    // Hold a stalled report
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled report changed or dropped");

    // A run that is not finished continues in the next cycle
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=> out_valid)
        else $error("report run broken");

    // Static part B always closes its run
    a_b_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.report_kind == KIND_STATIC_B) |-> out_data.last_of_run)
        else $error("static part B not last");

    // Static part A is always followed by part B
    a_a_then_b: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (out_data.report_kind == KIND_STATIC_A)
        |=> out_valid && (out_data.report_kind == KIND_STATIC_B))
        else $error("static part A not followed by part B");

endmodule

bind position_static_report_scheduler psrs_checker u_psrs_checker (.*);

>>> test/psrs_report_board_pkg.sv
`timescale 1ns / 1ps
// Report scoreboard for the position/static report scheduler testbench.
// Predicts the reports of each accepted event and checks what the block sends.
// Depends on psrs_pkg for payload types, codes and widths.
package psrs_report_board_pkg;
    import psrs_pkg::*;

    class report_schedule_board;
        // Register copies
        logic [INTERVAL_BITS-1:0] slow_iv;
        logic [INTERVAL_BITS-1:0] fast_iv;
        logic [INTERVAL_BITS-1:0] static_iv;
        logic [SPEED_IN_BITS-1:0] speed_limit;
        logic                     station_on;
        // Scheduler state
        logic [TIME_BITS-1:0]     now_s;
        logic [TIME_BITS-1:0]     last_pos;
        logic [TIME_BITS-1:0]     last_static;
        logic [SPEED_BITS-1:0]    smooth;
        logic                     pos_chan;
        logic                     static_chan;
        // Reports owed by the block, oldest first
        out_item_t                due_reports[$];
        int                       mismatches;

        function new();
            slow_iv     = 16'd180;
            fast_iv     = 16'd30;
            static_iv   = 16'd360;
            speed_limit = 14'd32;
            station_on  = 1'b0;
            now_s       = '0;
            last_pos    = '0;
            last_static = '0;
            smooth      = '0;
            pos_chan    = 1'b0;
            static_chan = 1'b0;
            mismatches  = 0;
        endfunction

        task flag(string what);
            mismatches++;
            if (mismatches <= 100)
                $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        function int pending();
            return due_reports.size();
        endfunction

        function void note_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_SLOW_INTERVAL:   slow_iv = value;
                REG_FAST_INTERVAL:   fast_iv = value;
                REG_STATIC_INTERVAL: static_iv = value;
                REG_SPEED_THRESHOLD: speed_limit = value[SPEED_IN_BITS-1:0];
                REG_STATION_VALID:   station_on = value[0];
                default: ;
            endcase
        endfunction

        function out_item_t make_report(logic [1:0] kind, logic chan);
            out_item_t rep;
            rep.report_kind = kind;
            rep.tx_channel  = chan;
            rep.last_of_run = 1'b0;
            return rep;
        endfunction

        // Advance the state for one accepted event and queue its reports.
        function void note_event(in_item_t ev);
            out_item_t                run[$];
            out_item_t                tail;
            logic [31:0]              blend;
            logic [INTERVAL_BITS-1:0] iv;
            logic [TIME_BITS-1:0]     span;
            case (ev.command)
                CMD_FIX: begin
                    if (ev.channels_ready && ev.radio_ready && ev.send_permitted && now_s != '0)
                    begin
                        blend = (32'(smooth) << 2) + (32'(ev.fix_speed) << SPEED_FRAC) + 32'd2;
                        smooth = SPEED_BITS'(blend / 32'd5);
                        iv = (32'(smooth) < (32'(speed_limit) << SPEED_FRAC)) ? slow_iv : fast_iv;
                        span = now_s - last_pos;
                        if (span > TIME_BITS'(iv))
                        begin
                            if (station_on)
                                run.push_back(make_report(KIND_POSITION, pos_chan));
                            pos_chan = ~pos_chan;
                            last_pos = now_s;
                        end
                        span = now_s - last_static;
                        if (span > TIME_BITS'(static_iv))
                        begin
                            if (station_on)
                            begin
                                run.push_back(make_report(KIND_STATIC_A, static_chan));
                                run.push_back(make_report(KIND_STATIC_B, static_chan));
                            end
                            static_chan = ~static_chan;
                            last_static = now_s;
                        end
                    end
                end
                CMD_CLOCK: begin
                    if (now_s == '0)
                    begin
                        last_pos    = ev.clock_time - TIME_BITS'(slow_iv >> 1);
                        last_static = ev.clock_time - TIME_BITS'(static_iv >> 1);
                    end
                    now_s = ev.clock_time;
                end
                CMD_INTERROG: begin
                    if (station_on && ev.requested_type == MSG_POSITION)
                        run.push_back(make_report(KIND_POSITION, ev.requested_channel));
                    else if (station_on && ev.requested_type == MSG_STATIC)
                    begin
                        run.push_back(make_report(KIND_STATIC_A, ev.requested_channel));
                        run.push_back(make_report(KIND_STATIC_B, ev.requested_channel));
                    end
                end
                default: ;
            endcase
            if (run.size() > 0)
            begin
                tail = run[run.size() - 1];
                tail.last_of_run = 1'b1;
                run[run.size() - 1] = tail;
            end
            foreach (run[i])
                due_reports.push_back(run[i]);
        endfunction

        task check_report(out_item_t got);
            out_item_t want;
            if (due_reports.size() == 0)
            begin
                flag($sformatf("report kind %0d chan %0d with nothing expected",
                               got.report_kind, got.tx_channel));
                return;
            end
            want = due_reports.pop_front();
            if (got.report_kind !== want.report_kind)
                flag($sformatf("report_kind %0d, expected %0d",
                               got.report_kind, want.report_kind));
            if (got.tx_channel !== want.tx_channel)
                flag($sformatf("tx_channel %0d, expected %0d (kind %0d)",
                               got.tx_channel, want.tx_channel, want.report_kind));
            if (got.last_of_run !== want.last_of_run)
                flag($sformatf("last_of_run %0d, expected %0d (kind %0d)",
                               got.last_of_run, want.last_of_run, want.report_kind));
        endtask
    endclass

endpackage

>>> test/tb_position_static_report_scheduler.sv
`timescale 1ns / 1ps
// Testbench top for position_static_report_scheduler: drives clock, fix and
// interrogation events, programs the registers, and checks every report.
// Depends on psrs_pkg, psrs_report_board_pkg and the design files.
module tb_position_static_report_scheduler;
    import psrs_pkg::*;
    import psrs_report_board_pkg::*;

    // Command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Idle cycles after the last report before touching the registers; covers
    // an event that produces nothing and still sits in the input register
    localparam int SETTLE_CYCLES = 8;
    // Slowest legal run is roughly 500 events, each with a sender gap and up to
    // three stalled reports, plus drains; take it many times over
    localparam int CYCLE_LIMIT = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     in_valid;
    logic                     in_ready;
    in_item_t                 in_data;
    logic                     out_valid;
    logic                     out_ready;
    out_item_t                out_data;

    report_schedule_board board;
    bit                   sender_idles;
    bit                   receiver_idles;
    // Time value the stimulus last put on the block
    logic [31:0]          wall;

    position_static_report_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog: end a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // Check every report transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_report(out_data);
    end

    // Receiver: stall in random bursts while idling is enabled
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Fill every field at random so unused bits toggle too
    function automatic in_item_t random_fields();
        in_item_t ev;
        ev.command           = 2'($urandom);
        ev.clock_time        = $urandom;
        ev.fix_speed         = 14'($urandom);
        ev.channels_ready    = 1'($urandom);
        ev.radio_ready       = 1'($urandom);
        ev.send_permitted    = 1'($urandom);
        ev.requested_type    = 6'($urandom);
        ev.requested_channel = 1'($urandom);
        return ev;
    endfunction

    function automatic in_item_t make_clock(logic [31:0] t);
        in_item_t ev;
        ev = random_fields();
        ev.command    = CMD_CLOCK;
        ev.clock_time = t;
        return ev;
    endfunction

    // gates_on forces all three readiness flags high; otherwise they are random
    function automatic in_item_t make_fix(logic [SPEED_IN_BITS-1:0] speed, bit gates_on);
        in_item_t ev;
        ev = random_fields();
        ev.command   = CMD_FIX;
        ev.fix_speed = speed;
        if (gates_on)
        begin
            ev.channels_ready = 1'b1;
            ev.radio_ready    = 1'b1;
            ev.send_permitted = 1'b1;
        end
        return ev;
    endfunction

    function automatic in_item_t make_query(logic [TYPE_BITS-1:0] msg, logic chan);
        in_item_t ev;
        ev = random_fields();
        ev.command           = CMD_INTERROG;
        ev.requested_type    = msg;
        ev.requested_channel = chan;
        return ev;
    endfunction

    // Present one event and hold it until the transfer. Enter and leave at a
    // falling edge; valid stays high on exit so back-to-back events never
    // drop it within one step.
    task automatic send_event(input in_item_t ev);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_event(ev);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted report has left the block
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        board.note_write(idx, value);
        @(negedge clk);
    endtask

    // Program all registers while idle. Pad the narrow ones with random upper
    // bits, and add a write to an index past the list that must be ignored.
    task automatic apply_settings(input logic [INTERVAL_BITS-1:0] slow,
                                  input logic [INTERVAL_BITS-1:0] fast,
                                  input logic [INTERVAL_BITS-1:0] stat,
                                  input logic [SPEED_IN_BITS-1:0] thr,
                                  input logic                     valid_id);
        logic [CFG_DATA_BITS-1:0] pad;
        drain();
        pad = 16'($urandom);
        write_reg(REG_SLOW_INTERVAL, slow);
        write_reg(CFG_IDX_BITS'($urandom_range(CFG_COUNT, (1 << CFG_IDX_BITS) - 1)),
                  16'($urandom));
        write_reg(REG_FAST_INTERVAL, fast);
        write_reg(REG_STATIC_INTERVAL, stat);
        write_reg(REG_SPEED_THRESHOLD, {pad[CFG_DATA_BITS-1:SPEED_IN_BITS], thr});
        write_reg(REG_STATION_VALID, {pad[CFG_DATA_BITS-1:1], valid_id});
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed traffic: clock ticks that walk time forward, gated
    // fixes, interrogations, and a little noise. span_max sets the time step.
    task automatic run_phase(input int events, input int unsigned span_max);
        int                       pick;
        int                       sel;
        logic [SPEED_IN_BITS-1:0] speed;
        repeat (events)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                sel = $urandom_range(0, 39);
                if (sel == 0)
                    wall = '0;          // time unknown again; next tick reseeds
                else if (sel < 3)
                    wall = $urandom;    // jump anywhere, wrap included
                else
                    wall = wall + $urandom_range(0, span_max);
                send_event(make_clock(wall));
            end
            else if (pick < 78)
            begin
                sel = $urandom_range(0, 7);
                if (sel == 0)
                    speed = '0;
                else if (sel == 1)
                    speed = '1;
                else if (sel < 4)
                    speed = 14'($urandom_range(0, 600));
                else
                    speed = 14'($urandom);
                send_event(make_fix(speed, $urandom_range(0, 9) != 0));
            end
            else if (pick < 93)
            begin
                sel = $urandom_range(0, 4);
                if (sel < 2)
                    send_event(make_query(MSG_POSITION, 1'($urandom)));
                else if (sel < 4)
                    send_event(make_query(MSG_STATIC, 1'($urandom)));
                else
                    send_event(make_query(6'($urandom), 1'($urandom)));
            end
            else
                send_event(random_fields());
            // Now and then hold the sender until the block has emptied
            if ($urandom_range(0, 49) == 0)
                drain();
        end
    endtask

    function automatic int unsigned span_for(input logic [INTERVAL_BITS-1:0] a,
                                             input logic [INTERVAL_BITS-1:0] b);
        return ((a > b) ? a : b) / 3 + 2;
    endfunction

    initial
    begin
        in_item_t                 ev;
        logic [INTERVAL_BITS-1:0] slow;
        logic [INTERVAL_BITS-1:0] fast;
        logic [INTERVAL_BITS-1:0] stat;
        int                       waited;

        board = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        wall = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: power-up registers, station not yet valid
        send_event(make_fix('1, 1'b1));               // time unknown: fix is gated
        send_event(make_query(MSG_POSITION, 1'b1));   // station not valid: silent
        send_event(make_clock('0));                   // zero time keeps it unknown
        send_event(make_clock(32'd1000));             // first tick seeds last times
        ev = make_fix(14'd100, 1'b1);
        ev.channels_ready = 1'b0;
        send_event(ev);
        ev = make_fix(14'd100, 1'b1);
        ev.radio_ready = 1'b0;
        send_event(ev);
        ev = make_fix(14'd100, 1'b1);
        ev.send_permitted = 1'b0;
        send_event(ev);
        send_event(make_clock(32'd1200));
        send_event(make_fix(14'd100, 1'b1));          // both due, silent, channels flip

        // Directed: station valid, interrogations and wrap of time
        apply_settings(16'd180, 16'd30, 16'd360, 14'd32, 1'b1);
        send_event(make_query(MSG_POSITION, 1'b1));
        send_event(make_query(MSG_STATIC, 1'b0));
        send_event(make_query(MSG_STATIC, 1'b1));
        send_event(make_query('0, 1'b0));             // other message numbers ignored
        send_event(make_query('1, 1'b1));
        ev = random_fields();
        ev.command = CMD_UNUSED;
        send_event(ev);
        send_event(make_clock(32'hFFFF_FFF0));
        send_event(make_fix('1, 1'b1));               // position plus both static parts
        send_event(make_clock(32'h0000_0020));        // time wraps
        send_event(make_fix('0, 1'b1));               // fast interval, position only
        ev = make_fix('1, 1'b1);
        ev.channels_ready = 1'b0;
        ev.radio_ready = 1'b0;
        ev.send_permitted = 1'b0;
        send_event(ev);
        wall = 32'h0000_0020;

        // Random: default-like intervals, both sides idle
        apply_settings(16'd180, 16'd30, 16'd360, 14'd32, 1'b1);
        run_phase(60, 130);

        // Zero intervals and threshold: a report on nearly every fix, no idling
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        apply_settings('0, '0, '0, '0, 1'b1);
        run_phase(50, 3);

        // Largest intervals and threshold
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        apply_settings('1, '1, '1, '1, 1'b1);
        run_phase(60, span_for(16'hFFFF, 16'hFFFF));

        // Small random intervals, receiver stalls only
        sender_idles = 1'b0;
        slow = 16'($urandom_range(0, 200));
        fast = 16'($urandom_range(0, 60));
        stat = 16'($urandom_range(0, 400));
        apply_settings(slow, fast, stat, 14'($urandom_range(0, 600)), 1'b1);
        run_phase(60, span_for(slow, stat));

        // Station not valid: state moves, nothing comes out
        sender_idles = 1'b1;
        apply_settings(16'($urandom_range(0, 200)), 16'($urandom_range(0, 60)),
                       16'($urandom_range(0, 400)), 14'($urandom), 1'b0);
        run_phase(40, 100);

        // Full-range random registers
        slow = 16'($urandom);
        fast = 16'($urandom);
        stat = 16'($urandom);
        apply_settings(slow, fast, stat, 14'($urandom), 1'b1);
        run_phase(60, span_for(slow, stat));

        // Small random intervals, sender gaps only
        receiver_idles = 1'b0;
        slow = 16'($urandom_range(0, 120));
        fast = 16'($urandom_range(0, 40));
        stat = 16'($urandom_range(0, 250));
        apply_settings(slow, fast, stat, 14'($urandom_range(0, 400)), 1'b1);
        run_phase(60, span_for(slow, stat));

        // Closing stretch at full rate on both sides
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        slow = 16'($urandom_range(0, 120));
        fast = 16'($urandom_range(0, 40));
        stat = 16'($urandom_range(0, 250));
        apply_settings(slow, fast, stat, 14'($urandom_range(0, 400)), 1'b1);
        run_phase(60, span_for(slow, stat));

        // Wait out the last reports, bounded
        in_valid <= 1'b0;
        waited = 0;
        while (board.pending() != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (board.pending() != 0)
            board.flag($sformatf("%0d predicted reports never arrived", board.pending()));

        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
